/* design/qse_pkg.sv */
// Shared types, constants and byte classification for the quoted string escaper.
// No dependencies; every other design file imports this package.
package qse_pkg;

  localparam int LENGTH_BITS = 10;            // width of the escaped-byte counter
  localparam int MAX_LEN_W   = 10;            // width of the max_length register
  localparam int CMP_W       = (LENGTH_BITS > MAX_LEN_W) ? LENGTH_BITS : MAX_LEN_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = MAX_LEN_W;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam int STEP_W      = 4;             // up to ten output words per input word

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(400);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_AT_NUL  = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef enum logic [1:0] {
    BODY_NONE  = 2'd0,   // byte dropped
    BODY_PLAIN = 2'd1,   // byte as is
    BODY_ESC   = 2'd2,   // backslash and a letter (or the quoted char)
    BODY_OCT   = 2'd3    // backslash and three octal digits
  } body_kind_t;

  typedef enum logic [1:0] {
    CLOSE_NONE     = 2'd0,
    CLOSE_QUOTE    = 2'd1,
    CLOSE_ELLIPSIS = 2'd2
  } close_kind_t;

  // One classified input word, as passed from front to back.
  typedef struct packed {
    logic        open_quote;
    body_kind_t  body;
    logic [7:0]  ch;
    close_kind_t close_kind;
  } desc_t;

  // Fixed pass-through set: 32..126 and 161..254, minus quote and backslash.
  function automatic logic is_printable(input logic [7:0] b);
    logic in_set;
    in_set = ((b >= 8'd32) && (b < 8'd127)) || ((b >= 8'd161) && (b < 8'd255));
    return in_set && (b != CH_QUOTE) && (b != CH_BSLASH);
  endfunction

  // Short escape: {hit, letter}
  function automatic logic [8:0] short_escape(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      8'd7:      r = {1'b1, 8'h61};  // a
      8'd8:      r = {1'b1, 8'h62};  // b
      8'd12:     r = {1'b1, 8'h66};  // f
      8'd10:     r = {1'b1, 8'h6E};  // n
      8'd13:     r = {1'b1, 8'h72};  // r
      8'd9:      r = {1'b1, 8'h74};  // t
      8'd11:     r = {1'b1, 8'h76};  // v
      default:   r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

endpackage

/* design/qse_front.sv */
// Front end: configuration registers, string state and per-word classification.
// Depends on qse_pkg; feeds qse_fifo.
module qse_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [qse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qse_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          first_byte,
  input  logic                          last_byte,
  input  logic                          fifo_full,
  output logic                          push,
  output qse_pkg::desc_t                push_desc
);
  import qse_pkg::*;

  logic                   raw_mode;
  logic                   limit_enable;
  logic [MAX_LEN_W-1:0]   max_length;
  logic                   stop_at_nul;

  logic [LENGTH_BITS-1:0] bytes_seen, bytes_seen_next, bs_cur;
  logic                   over_limit, over_limit_next, ol_cur;
  logic                   nul_seen, nul_seen_next, nul_cur;
  logic [8:0]             esc;
  logic                   accept;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode     <= 1'b0;
      limit_enable <= 1'b1;
      max_length   <= MAX_LEN_RESET;
      stop_at_nul  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RAW_MODE:     raw_mode     <= cfg_data[0];
        REG_LIMIT_ENABLE: limit_enable <= cfg_data[0];
        REG_MAX_LENGTH:   max_length   <= cfg_data[MAX_LEN_W-1:0];
        REG_STOP_AT_NUL:  stop_at_nul  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bs_cur  = first_byte ? '0   : bytes_seen;
    ol_cur  = first_byte ? 1'b0 : over_limit;
    nul_cur = first_byte ? 1'b0 : nul_seen;
    bytes_seen_next = bs_cur;
    over_limit_next = ol_cur;
    nul_seen_next   = nul_cur;
    esc = short_escape(data_byte);

    push_desc.open_quote = first_byte && !raw_mode;
    push_desc.body       = BODY_NONE;
    push_desc.ch         = data_byte;
    push_desc.close_kind = CLOSE_NONE;

    if (!nul_cur) begin
      if (stop_at_nul && (data_byte == 8'd0)) nul_seen_next = 1'b1;
      if (raw_mode) begin
        push_desc.body = BODY_PLAIN;
      end else if (limit_enable && (CMP_W'(bs_cur) >= CMP_W'(max_length))) begin
        over_limit_next = 1'b1;
      end else begin
        if (is_printable(data_byte)) begin
          push_desc.body = BODY_PLAIN;
        end else if (esc[8]) begin
          push_desc.body = BODY_ESC;
          push_desc.ch   = esc[7:0];
        end else begin
          push_desc.body = BODY_OCT;
        end
        if (limit_enable) bytes_seen_next = bs_cur + LENGTH_BITS'(1);
      end
    end

    if (last_byte && !raw_mode)
      push_desc.close_kind = over_limit_next ? CLOSE_ELLIPSIS : CLOSE_QUOTE;
  end

  // drop words that produce no output at all
  assign push = accept && (push_desc.open_quote || (push_desc.body != BODY_NONE) ||
                           (push_desc.close_kind != CLOSE_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      over_limit <= 1'b0;
      nul_seen   <= 1'b0;
    end else if (accept) begin
      bytes_seen <= bytes_seen_next;
      over_limit <= over_limit_next;
      nul_seen   <= nul_seen_next;
    end
  end

endmodule

/* design/qse_fifo.sv */
// Short descriptor queue between front and back end.
// Depends on qse_pkg.
module qse_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qse_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output qse_pkg::desc_t head
);
  import qse_pkg::*;

  desc_t                 entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push, do_pop;

  assign full    = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

/* design/qse_back.sv */
// Back end: expands a descriptor into output words, one per cycle unless stalled, via an output register.
// Depends on qse_pkg; reads the head of qse_fifo.
module qse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  qse_pkg::desc_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           run_end,
  output logic           literal_end
);
  import qse_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] body_len, close_len, total_len, j, c;
  logic [7:0]        cur_byte;
  logic              cur_last, advance;

  always_comb begin
    case (head.body)
      BODY_PLAIN: body_len = STEP_W'(1);
      BODY_ESC:   body_len = STEP_W'(2);
      BODY_OCT:   body_len = STEP_W'(4);
      default:    body_len = '0;
    endcase
    case (head.close_kind)
      CLOSE_QUOTE:    close_len = STEP_W'(1);
      CLOSE_ELLIPSIS: close_len = STEP_W'(5);
      default:        close_len = '0;
    endcase
    total_len = STEP_W'(head.open_quote) + body_len + close_len;
    j = step - STEP_W'(head.open_quote);
    c = j - body_len;
    cur_byte = CH_QUOTE;

    if (head.open_quote && (step == '0)) begin
      cur_byte = CH_QUOTE;
    end else if (j < body_len) begin
      case (head.body)
        BODY_PLAIN: cur_byte = head.ch;
        BODY_ESC:   cur_byte = (j == '0) ? CH_BSLASH : head.ch;
        BODY_OCT: begin
          case (j)
            STEP_W'(0): cur_byte = CH_BSLASH;
            STEP_W'(1): cur_byte = CH_ZERO + {6'd0, head.ch[7:6]};
            STEP_W'(2): cur_byte = CH_ZERO + {5'd0, head.ch[5:3]};
            default:    cur_byte = CH_ZERO + {5'd0, head.ch[2:0]};
          endcase
        end
        default:    cur_byte = head.ch;
      endcase
    end else if (head.close_kind == CLOSE_ELLIPSIS) begin
      case (c)
        STEP_W'(0):                         cur_byte = CH_SPACE;
        STEP_W'(1), STEP_W'(2), STEP_W'(3): cur_byte = CH_DOT;
        default:                            cur_byte = CH_QUOTE;
      endcase
    end else begin
      cur_byte = CH_QUOTE;
    end
    cur_last = (step == (total_len - STEP_W'(1)));
  end

  assign advance = head_valid && (!out_valid || out_ready);
  assign pop     = advance && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        step      <= cur_last ? '0 : step + STEP_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= cur_byte;
      run_end     <= cur_last;
      literal_end <= cur_last && (head.close_kind != CLOSE_NONE);
    end
  end

endmodule

/* design/quoted_string_escaper.sv */
// Top level of the quoted string escaper: front end, descriptor queue, back end.
// Depends on qse_pkg, qse_front, qse_fifo, qse_back.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in_valid/in_ready    | data_byte, first_byte, last_byte
//   out     | out_valid/out_ready  | out_byte, run_end, literal_end
//
// An input word is taken whenever the queue has room; it then yields 0 to 10
// output words, one per cycle while the output is not stalled, through the back
// end's single output port: one word for a plain byte, two for a short
// escape, four for an octal escape, plus one for the opening quote and one
// (quote) or five (ellipsis) for the close. A dropped word is never queued.
// The first output word of a word passes the queue, then the output register.
// Reset (rst, synchronous) empties the queue and output register and loads
// the register defaults. A stalled output holds its word; the front keeps
// accepting until the four-entry queue fills. Config writes are always taken.
module quoted_string_escaper (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qse_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           first_byte,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           run_end,
  output logic                           literal_end
);
  import qse_pkg::*;

  logic  push, pop, fifo_full, fifo_empty;
  desc_t push_desc, head;

  // registers are plain flops, a write never has to wait
  assign cfg_ready = 1'b1;

  // classify each word and track limit / nul state
  qse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_desc  (push_desc)
  );

  // decouple classification from expansion
  qse_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (fifo_full),
    .empty     (fifo_empty),
    .head      (head)
  );

  // walk each descriptor one output word per cycle while the output is not stalled
  qse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!fifo_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_end     (run_end),
    .literal_end (literal_end)
  );

endmodule

/* design/qse_checker.sv */
// Port-level checks for quoted_string_escaper, attached by bind.
// Depends on qse_pkg.
module qse_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [7:0]                     data_byte,
  input logic                           first_byte,
  input logic                           last_byte,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [7:0]                     out_byte,
  input logic                           run_end,
  input logic                           literal_end
);
  import qse_pkg::*;

  // hold a waiting input word
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(first_byte)
                              && $stable(last_byte))
    else $error("waiting input word changed");

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_end)
                                && $stable(literal_end))
    else $error("stalled output word changed");

  a_lit_end_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && literal_end |-> run_end)
    else $error("literal_end without run_end");

  a_lit_end_quote: assert property (@(posedge clk) disable iff (rst)
    out_valid && literal_end |-> out_byte == CH_QUOTE)
    else $error("literal_end on a byte other than the closing quote");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind quoted_string_escaper qse_checker u_qse_checker (.*);

/* dv/quoted_string_escaper_tb.sv */
`timescale 1ns / 100ps
// Testbench for quoted_string_escaper: sends byte strings under several register
// settings, predicts the quoted literal word by word and checks every output word.
// Depends on qse_pkg and the quoted_string_escaper design files.
module quoted_string_escaper_tb;
  import qse_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 48;      // quiet margin after the last owed word
  localparam int CYCLE_LIMIT   = 600000;

  // One output word as the escaper should present it.
  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       lit_end;
  } lit_word_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            data_byte;
  logic                  first_byte;
  logic                  last_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  logic                  run_end;
  logic                  literal_end;

  // Register copies, updated on each accepted config write.
  logic                  mode_raw;
  logic                  mode_limit;
  logic [MAX_LEN_W-1:0]  mode_max_len;
  logic                  mode_nul_stop;

  // Escaper state as the predictor tracks it.
  logic [LENGTH_BITS-1:0] escaped_count;
  logic                   truncated;
  logic                   nul_hit;

  lit_word_t expected_words[$];   // literal words still owed by the block
  lit_word_t step_words[$];       // words caused by the input word being predicted

  int fail_count    = 0;
  int cycle_count   = 0;
  int send_gap_pct  = 0;          // chance of a sender gap before a word
  int stall_pct     = 0;          // chance of a receiver stall burst
  bit quiet_tail    = 1'b0;       // no idling on either side once set

  quoted_string_escaper u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_end     (run_end),
    .literal_end (literal_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycle_count,
               expected_words.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    $display("%0t: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void emit(input logic [7:0] c);
    lit_word_t w;
    w.ch      = c;
    w.run_end = 1'b0;
    w.lit_end = 1'b0;
    step_words.push_back(w);
  endfunction

  // Escape one body byte: printable bytes stand as they are, quote and
  // backslash and the seven control letters get a backslash, the rest go octal.
  function automatic void emit_escaped(input logic [7:0] b);
    logic plain;
    plain = ((b >= 8'd32 && b <= 8'd126) || (b >= 8'd161 && b <= 8'd254)) &&
            b != CH_QUOTE && b != CH_BSLASH;
    if (plain) begin
      emit(b);
    end else begin
      emit(CH_BSLASH);
      case (b)
        CH_QUOTE, CH_BSLASH: emit(b);
        8'd7:    emit("a");
        8'd8:    emit("b");
        8'd12:   emit("f");
        8'd10:   emit("n");
        8'd13:   emit("r");
        8'd9:    emit("t");
        8'd11:   emit("v");
        default: begin
          emit(CH_ZERO + {6'd0, b[7:6]});
          emit(CH_ZERO + {5'd0, b[5:3]});
          emit(CH_ZERO + {5'd0, b[2:0]});
        end
      endcase
    end
  endfunction

  // Work out the words that one accepted input word causes and queue them.
  function automatic void escape_predict(input logic [7:0] b, input logic f, input logic l);
    logic      closing;
    lit_word_t w;
    int        n;
    closing = 1'b0;
    step_words.delete();
    // a first mark restarts the literal, abandoning any open one
    if (f) begin
      escaped_count = '0;
      truncated     = 1'b0;
      nul_hit       = 1'b0;
      if (!mode_raw)
        emit(CH_QUOTE);
    end
    // after a nul in stop mode every byte is dropped, raw mode included
    if (!nul_hit) begin
      if (mode_nul_stop && b == 8'h00)
        nul_hit = 1'b1;
      if (mode_raw) begin
        emit(b);
      end else if (mode_limit && escaped_count >= mode_max_len) begin
        truncated = 1'b1;
      end else begin
        emit_escaped(b);
        if (mode_limit)
          escaped_count = escaped_count + 1'b1;
      end
    end
    // close the literal, with the ellipsis when anything was cut
    if (l && !mode_raw) begin
      if (truncated) begin
        emit(CH_SPACE);
        emit(CH_DOT);
        emit(CH_DOT);
        emit(CH_DOT);
      end
      emit(CH_QUOTE);
      closing = 1'b1;
    end
    n = step_words.size();
    if (n > 0) begin
      w = step_words[n-1];
      w.run_end = 1'b1;
      w.lit_end = closing;
      step_words[n-1] = w;
    end
    foreach (step_words[i])
      expected_words.push_back(step_words[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Output side: random stalls and the word checker
  // ---------------------------------------------------------------------

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted word with the oldest one owed, field by field.
  always @(posedge clk) begin : check_words
    lit_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        note_failure($sformatf("unexpected word: expected none, actual out_byte=%02h",
                               out_byte));
      end else begin
        want = expected_words.pop_front();
        if (out_byte !== want.ch)
          note_failure($sformatf("out_byte: expected %02h, actual %02h", want.ch, out_byte));
        if (run_end !== want.run_end)
          note_failure($sformatf("run_end: expected %0b, actual %0b (out_byte %02h)",
                                 want.run_end, run_end, want.ch));
        if (literal_end !== want.lit_end)
          note_failure($sformatf("literal_end: expected %0b, actual %0b (out_byte %02h)",
                                 want.lit_end, literal_end, want.ch));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------

  // Send one input word; predict it at the edge where it is taken.
  task automatic send_word(input logic [7:0] b, input logic f, input logic l);
    if (!quiet_tail && send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    first_byte <= f;
    last_byte  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    escape_predict(b, f, l);
  endtask

  // Drop valid and hold until every owed word has come out.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Drain, then give dropped words still in flight time to leave the block.
  task automatic settle_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One config write; valid stays as the caller left it.
  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RAW_MODE:     mode_raw      = val[0];
      REG_LIMIT_ENABLE: mode_limit    = val[0];
      REG_MAX_LENGTH:   mode_max_len  = val[MAX_LEN_W-1:0];
      REG_STOP_AT_NUL:  mode_nul_stop = val[0];
      default: ;
    endcase
  endtask

  // Write all four registers back to back; call only while the block is idle.
  task automatic apply_settings(input logic raw, input logic lim,
                                input logic [MAX_LEN_W-1:0] max_len, input logic nul);
    cfg_valid <= 1'b1;
    cfg_beat(REG_RAW_MODE, CFG_DATA_W'(raw));
    cfg_beat(REG_LIMIT_ENABLE, CFG_DATA_W'(lim));
    cfg_beat(REG_MAX_LENGTH, CFG_DATA_W'(max_len));
    cfg_beat(REG_STOP_AT_NUL, CFG_DATA_W'(nul));
    cfg_valid <= 1'b0;
  endtask

  // Bias toward the byte classes that escape differently.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: b = 8'($urandom_range(32, 126));
      1: begin
        case ($urandom_range(0, 3))
          0:       b = 8'h00;
          1:       b = 8'($urandom_range(7, 13));
          2:       b = CH_QUOTE;
          default: b = CH_BSLASH;
        endcase
      end
      2:       b = 8'($urandom_range(127, 255));
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  task automatic send_random_string(input int len);
    for (int k = 0; k < len; k++)
      send_word(pick_byte(), k == 0, k == len - 1);
  endtask

  // Mostly well-formed strings; the rest carry random marks.
  task automatic run_random_phase(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 10);
        send_random_string(len);
        sent += len;
      end else begin
        send_word(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Every escape class at reset settings, boundaries of the printable ranges included.
  task automatic test_escape_classes();
    logic [7:0] probe [17] = '{8'h20, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13,
                               CH_QUOTE, CH_BSLASH, 8'h1F, 8'h7E, 8'h7F, 8'hA0,
                               8'hA1, 8'hFE, 8'hFF};
    foreach (probe[i])
      send_word(probe[i], i == 0, i == 16);
  endtask

  // Abandoned literal, words with no marks after a close, last mark alone.
  task automatic test_mark_handling();
    send_word("a", 1'b1, 1'b0);
    send_word("b", 1'b1, 1'b1);
    send_word("z", 1'b0, 1'b0);
    send_word("y", 1'b0, 1'b1);
  endtask

  // Zero length drops everything; length one cuts after the first byte.
  task automatic test_truncation();
    settle_idle();
    apply_settings(1'b0, 1'b1, 10'd0, 1'b0);
    send_word("q", 1'b1, 1'b1);
    settle_idle();
    apply_settings(1'b0, 1'b1, 10'd1, 1'b0);
    send_word("a", 1'b1, 1'b0);
    send_word("b", 1'b0, 1'b0);
    send_word("c", 1'b0, 1'b1);
    // over the limit with no last mark: nothing comes out
    send_word("x", 1'b0, 1'b0);
  endtask

  // Nul stop in escaped and in raw display.
  task automatic test_nul_stop();
    settle_idle();
    apply_settings(1'b0, 1'b1, MAX_LEN_RESET, 1'b1);
    send_word("a", 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word("b", 1'b0, 1'b1);
    settle_idle();
    apply_settings(1'b1, 1'b1, MAX_LEN_RESET, 1'b1);
    send_word("x", 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word("y", 1'b0, 1'b1);
  endtask

  // No limit with a length of one, then a string under the largest length.
  task automatic test_length_extremes();
    settle_idle();
    apply_settings(1'b0, 1'b0, 10'd1, 1'b0);
    send_random_string(12);
    settle_idle();
    apply_settings(1'b0, 1'b1, 10'd1023, 1'b0);
    for (int k = 0; k < 16; k++)
      send_word(8'(33 + k), k == 0, k == 15);
  endtask

  // Random strings across a sweep of settings, with idling on both sides in most phases.
  task automatic test_random_strings();
    send_gap_pct = 20;
    stall_pct    = 20;
    settle_idle();
    apply_settings(1'b0, 1'b1, 10'd4, 1'b0);
    run_random_phase(18);
    // pause the sender until the block has caught up, then carry on
    hold_until_drained();
    run_random_phase(6);
    settle_idle();
    apply_settings(1'b0, 1'b1, 10'($urandom_range(1, 8)), 1'b1);
    run_random_phase(18);
    settle_idle();
    apply_settings(1'b0, 1'b0, 10'd1, 1'b1);
    run_random_phase(12);
    settle_idle();
    apply_settings(1'b1, 1'b0, 10'd3, 1'b0);
    run_random_phase(10);
    // a stretch with no idling at all
    send_gap_pct = 0;
    stall_pct    = 0;
    settle_idle();
    apply_settings(1'b1, 1'b1, 10'd2, 1'b1);
    run_random_phase(10);
    send_gap_pct = 30;
    stall_pct    = 30;
    settle_idle();
    apply_settings(1'b0, 1'b1, 10'd1023, 1'b0);
    run_random_phase(10);
    // last part runs flat out
    quiet_tail = 1'b1;
    settle_idle();
    apply_settings(1'b0, 1'($urandom_range(0, 1)), 10'($urandom_range(1, 6)),
                   1'($urandom_range(0, 1)));
    run_random_phase(16);
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_RAW_MODE;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    data_byte  <= 8'h00;
    first_byte <= 1'b0;
    last_byte  <= 1'b0;
    // register defaults and cleared state, as reset leaves them
    mode_raw      = 1'b0;
    mode_limit    = 1'b1;
    mode_max_len  = MAX_LEN_RESET;
    mode_nul_stop = 1'b0;
    escaped_count = '0;
    truncated     = 1'b0;
    nul_hit       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_escape_classes();
    test_mark_handling();
    test_truncation();
    test_nul_stop();
    test_length_extremes();
    test_random_strings();

    settle_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
